### sv/dgls_pkg.sv
// Shared constants, command/status types and address helpers for the
// diagonal Gaussian log scorer. No dependencies.
package dgls_pkg;

    // Model geometry
    localparam int NUM_STATES     = 32;
    localparam int NUM_COMPONENTS = 4;
    localparam int MAX_DIM        = 64;

    localparam int NORM_DEPTH = NUM_STATES * NUM_COMPONENTS;
    localparam int VEC_DEPTH  = NORM_DEPTH * MAX_DIM;
    localparam int NORM_AW    = (NORM_DEPTH > 1) ? $clog2(NORM_DEPTH) : 1;
    localparam int VEC_AW     = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int STATE_W = 5;
    localparam int COMP_W  = 2;
    localparam int ELEM_W  = 6;
    localparam int SAMPLE_W = 16;
    localparam int IVAR_W  = 16;
    localparam int NORM_W  = 32;
    localparam int SCORE_W = 48;

    // Datapath widths
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int SQ_W        = 2 * DIFF_W - 1;
    localparam int TERM_W      = SQ_W + IVAR_W;
    localparam int SUM_W       = 56;
    localparam int ROUND_SHIFT = 17;
    localparam int HALF_W      = SUM_W + 1 - ROUND_SHIFT;

    // Operation codes (code 3 is unused and ignored)
    localparam logic [OP_W-1:0] OP_LOAD_VEC  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_NORM = 2'd1;
    localparam logic [OP_W-1:0] OP_SCORE     = 2'd2;

    typedef struct packed {
        logic load_vec;
        logic load_norm;
        logic start_score;
        logic square;
        logic mult;
        logic acc;
        logic half;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } dp_status_t;

    function automatic logic comp_in_range(logic [STATE_W-1:0] st, logic [COMP_W-1:0] cp);
        return (32'(st) < NUM_STATES) && (32'(cp) < NUM_COMPONENTS);
    endfunction

    function automatic logic elem_in_range(logic [STATE_W-1:0] st, logic [COMP_W-1:0] cp,
                                           logic [ELEM_W-1:0] el);
        return comp_in_range(st, cp) && (32'(el) < MAX_DIM);
    endfunction

    function automatic logic [NORM_AW-1:0] norm_addr(logic [STATE_W-1:0] st,
                                                     logic [COMP_W-1:0] cp);
        return NORM_AW'(32'(st) * NUM_COMPONENTS + 32'(cp));
    endfunction

    function automatic logic [VEC_AW-1:0] vec_addr(logic [STATE_W-1:0] st,
                                                   logic [COMP_W-1:0] cp,
                                                   logic [ELEM_W-1:0] el);
        return VEC_AW'((32'(st) * NUM_COMPONENTS + 32'(cp)) * MAX_DIM + 32'(el));
    endfunction

endpackage

### sv/dgls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dgls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/dgls_ctrl.sv
// Sequencer for the log scorer: accepts items, steps a score element through
// square, multiply, accumulate and, on the last element, round and emit.
// Depends on dgls_pkg.
module dgls_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                operation,
    input  dgls_pkg::dp_status_t      status,
    output dgls_pkg::ctrl_cmd_t       cmd
);
    import dgls_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SQUARE = 6'b000010,
        S_MULT   = 6'b000100,
        S_ACC    = 6'b001000,
        S_HALF   = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.load_vec    = accept && (operation == OP_LOAD_VEC);
        cmd.load_norm   = accept && (operation == OP_LOAD_NORM);
        cmd.start_score = accept && (operation == OP_SCORE);
        cmd.square      = (state_reg == S_SQUARE);
        cmd.mult        = (state_reg == S_MULT);
        cmd.acc         = (state_reg == S_ACC);
        cmd.half        = (state_reg == S_HALF);
        cmd.emit        = (state_reg == S_EMIT) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start_score)
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: state_next = S_MULT;
            S_MULT:   state_next = S_ACC;
            S_ACC:    state_next = status.last ? S_HALF : S_IDLE;
            S_HALF:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A score transfer always starts the element sequence
    a_score_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_score |=> (state_reg == S_SQUARE))
        else $error("score transfer did not start the sequence");

    // Emit is only reached through the rounding step
    a_emit_after_half: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ($past(state_reg) == S_HALF || $past(state_reg) == S_EMIT))
        else $error("emit state entered without rounding");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

### sv/dgls_datapath.sv
// Datapath of the log scorer: model RAMs, squared-difference and weighting
// multipliers, saturating distance sum, rounding and output register.
// Depends on dgls_pkg and dgls_ram.
module dgls_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dgls_pkg::ctrl_cmd_t          cmd,
    output dgls_pkg::dp_status_t         status,
    input  logic [4:0]                   state_index,
    input  logic [1:0]                   component_index,
    input  logic [5:0]                   element_index,
    input  logic signed [15:0]           sample_or_mean,
    input  logic [15:0]                  inverse_variance,
    input  logic signed [31:0]           log_normalizer,
    input  logic                         last_element,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic signed [47:0]           log_score
);
    import dgls_pkg::*;

    logic                 elem_ok;
    logic                 comp_ok;
    logic [VEC_AW-1:0]    vaddr;
    logic [NORM_AW-1:0]   naddr;
    logic [SAMPLE_W-1:0]  mean_rdata;
    logic [IVAR_W-1:0]    ivar_rdata;
    logic [NORM_W-1:0]    norm_rdata;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic                       elem_ok_reg;
    logic                       comp_ok_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [TERM_W-1:0]          term_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic [HALF_W-1:0]          half_reg;
    logic signed [SCORE_W-1:0]  out_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] sq_full;
    logic [TERM_W-1:0]          term_full;
    logic [SUM_W:0]             sum_wide;
    logic [SUM_W:0]             rounded;
    logic signed [SCORE_W-1:0]  logc;

    assign elem_ok = elem_in_range(state_index, component_index, element_index);
    assign comp_ok = comp_in_range(state_index, component_index);
    assign vaddr   = vec_addr(state_index, component_index, element_index);
    assign naddr   = norm_addr(state_index, component_index);

    dgls_ram #(.WIDTH(SAMPLE_W), .DEPTH(VEC_DEPTH)) u_mean_ram (
        .clk   (clk),
        .we    (cmd.load_vec && elem_ok),
        .waddr (vaddr),
        .wdata (sample_or_mean),
        .re    (cmd.start_score),
        .raddr (vaddr),
        .rdata (mean_rdata)
    );

    dgls_ram #(.WIDTH(IVAR_W), .DEPTH(VEC_DEPTH)) u_ivar_ram (
        .clk   (clk),
        .we    (cmd.load_vec && elem_ok),
        .waddr (vaddr),
        .wdata (inverse_variance),
        .re    (cmd.start_score),
        .raddr (vaddr),
        .rdata (ivar_rdata)
    );

    dgls_ram #(.WIDTH(NORM_W), .DEPTH(NORM_DEPTH)) u_norm_ram (
        .clk   (clk),
        .we    (cmd.load_norm && comp_ok),
        .waddr (naddr),
        .wdata (log_normalizer),
        .re    (cmd.start_score),
        .raddr (naddr),
        .rdata (norm_rdata)
    );

    // Exact Q.8 difference and its square
    assign diff    = DIFF_W'(sample_reg) - DIFF_W'($signed(mean_rdata));
    assign sq_full = diff * diff;

    // Q.24 term; out-of-range elements add nothing
    assign term_full = TERM_W'(sq_reg) * TERM_W'(ivar_rdata);

    // Saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(term_reg);

    // Half the sum in Q.8, rounded half up
    assign rounded = {1'b0, sum_reg} + (SUM_W + 1)'(1 << (ROUND_SHIFT - 1));

    assign logc = comp_ok_reg ? SCORE_W'($signed(norm_rdata)) : '0;

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.acc)
        begin
            sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        end
        else if (cmd.emit)
        begin
            sum_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_score)
        begin
            sample_reg  <= sample_or_mean;
            last_reg    <= last_element;
            elem_ok_reg <= elem_ok;
            comp_ok_reg <= comp_ok;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (cmd.mult)
        begin
            term_reg <= elem_ok_reg ? term_full : '0;
        end
        if (cmd.half)
        begin
            half_reg <= rounded[SUM_W:ROUND_SHIFT];
        end
        if (cmd.emit)
        begin
            out_reg <= logc - SCORE_W'(half_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign log_score = out_reg;

    // Emit only when the output register can take the result
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result emitted over a pending one");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && sum_reg == '0))
        else $error("emit did not present result or clear sum");

    // Accumulation never lowers the running sum
    a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |=> (sum_reg >= $past(sum_reg)))
        else $error("distance sum decreased on accumulate");

endmodule

### sv/diagonal_gaussian_log_score_top.sv
// Top level of the diagonal Gaussian log scorer.
// Depends on dgls_pkg, dgls_ctrl, dgls_datapath, dgls_ram.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_ready | operation, state_index, component_index,
//          |                     | element_index, sample_or_mean,
//          |                     | inverse_variance, log_normalizer,
//          |                     | last_element
//  output  | out_valid/out_ready | log_score (48-bit signed, Q.8)
//
// Steps: a load transfer writes the model RAMs at the transfer edge.
// A score element steps through RAM read, square, weight multiply and
// saturating accumulate, with the two multipliers chained; the last
// element of a frame adds round and emit.
// Reset: asynchronous active-low; clears the sequencer, the distance sum and
// the output valid. Model RAMs hold garbage until loaded.
// Stalls: a finished score sits in the output register while new items are
// taken; only the emit step of the next frame waits for that transfer.
module diagonal_gaussian_log_score_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [4:0]         state_index,
    input  logic [1:0]         component_index,
    input  logic [5:0]         element_index,
    input  logic signed [15:0] sample_or_mean,
    input  logic [15:0]        inverse_variance,
    input  logic signed [31:0] log_normalizer,
    input  logic               last_element,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] log_score
);
    import dgls_pkg::*;

    // Command and status buses between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    dgls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    dgls_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .state_index      (state_index),
        .component_index  (component_index),
        .element_index    (element_index),
        .sample_or_mean   (sample_or_mean),
        .inverse_variance (inverse_variance),
        .log_normalizer   (log_normalizer),
        .last_element     (last_element),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .log_score        (log_score)
    );

endmodule
